>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on clk_i, disabled in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Same, but also checked while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

>>> rtl/core/wwalu_pkg.sv
// Package for the 256-bit word arithmetic unit: request/result types and op codes.
// Depends on nothing.
package wwalu_pkg;
  localparam int unsigned LimbW    = 64;
  localparam int unsigned NumLimbs = 4;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned NumHalfs = 8;
  localparam int unsigned WordW    = LimbW * NumLimbs;
  // Column sum of up to eight 64-bit products plus carry, and the carry itself
  localparam int unsigned ColW     = 68;
  localparam int unsigned CyW      = ColW - HalfW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_SHL = 2'd3
  } op_e;

  typedef struct packed {
    op_e         kind;
    logic [63:0] a_limb3;
    logic [63:0] a_limb2;
    logic [63:0] a_limb1;
    logic [63:0] a_limb0;
    logic [63:0] b_limb3;
    logic [63:0] b_limb2;
    logic [63:0] b_limb1;
    logic [63:0] b_limb0;
    logic [7:0]  shift_bytes;
  } req_t;

  typedef struct packed {
    logic [63:0] r_limb3;
    logic [63:0] r_limb2;
    logic [63:0] r_limb1;
    logic [63:0] r_limb0;
  } res_t;

  // Item carried down the cell chain.
  typedef struct packed {
    op_e                             kind;
    logic [WordW-1:0]                a;
    logic [WordW-1:0]                b;
    logic [WordW-1:0]                acc;  // running result
    logic [NumHalfs-1:0][ColW-1:0]   col;  // unnormalised product columns
    logic [CyW-1:0]                  cy;   // carry/borrow into the next half
  } chain_t;
endpackage

>>> rtl/core/wwalu_cell.sv
// One cell of the chain: handles 32-bit half Idx of the result.
// Depends on wwalu_pkg.
module wwalu_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  wwalu_pkg::chain_t  data_i,
  output wwalu_pkg::chain_t  data_o
);
  import wwalu_pkg::*;

  chain_t               data_d, data_q;
  logic [HalfW-1:0]     xa, xb;
  logic [HalfW:0]       sum;
  logic [2*HalfW-1:0]   prod;
  logic [ColW-1:0]      col;

  assign xa = data_i.a[Idx*HalfW +: HalfW];
  assign xb = data_i.b[Idx*HalfW +: HalfW];

  always_comb begin
    data_d = data_i;
    sum    = '0;
    prod   = '0;
    col    = '0;
    case (data_i.kind)
      OP_ADD: begin
        sum = {1'b0, xa} + {1'b0, xb} + {{HalfW{1'b0}}, data_i.cy[0]};
        data_d.acc[Idx*HalfW +: HalfW] = sum[HalfW-1:0];
        data_d.cy = {{(CyW-1){1'b0}}, sum[HalfW]};
      end
      OP_SUB: begin
        sum = {1'b0, xa} - {1'b0, xb} - {{HalfW{1'b0}}, data_i.cy[0]};
        data_d.acc[Idx*HalfW +: HalfW] = sum[HalfW-1:0];
        data_d.cy = {{(CyW-1){1'b0}}, sum[HalfW]};
      end
      OP_MUL: begin
        // add row Idx (A times half Idx of B) into its columns, dropping
        // columns at and above 256 bits; column Idx is then complete
        for (int i = 0; i < NumHalfs - Idx; i++) begin
          prod = {{HalfW{1'b0}}, data_i.a[i*HalfW +: HalfW]} * {{HalfW{1'b0}}, xb};
          data_d.col[i+Idx] = data_i.col[i+Idx] + {{(ColW-2*HalfW){1'b0}}, prod};
        end
        col = data_d.col[Idx] + {{(ColW-CyW){1'b0}}, data_i.cy};
        data_d.acc[Idx*HalfW +: HalfW] = col[HalfW-1:0];
        data_d.cy = col[ColW-1:HalfW];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
endmodule

>>> rtl/core/wide_word_alu_256_unit.sv
// Top level of the 256-bit word arithmetic unit.
// Depends on wwalu_pkg and wwalu_cell.
//
// Usage:
//   Requests enter on req_valid_i/req_stall_o with a req_t payload; results
//   leave on res_valid_o/res_stall_i as res_t. One result per request, in
//   order. The unit takes one request every cycle while req_stall_o is low.
// Pipeline: the input register is loaded at acceptance; the request then
//   passes through eight 32-bit cells and the output register. Each cell
//   does one half of add/sub, or adds one row of 32x32 products into the
//   product columns and settles one column.
// Throughput: one request per cycle while res_stall_i is low.
// Reset: clears all valid bits; the pipeline then holds no request.
// Stall: when res_stall_i is high and the output holds a result, the whole
//   chain freezes and req_stall_o rises; no request is lost or repeated.
// The byte shift is done in the input stage and passed through the chain.
module wide_word_alu_256_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  wwalu_pkg::req_t   req_i,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output wwalu_pkg::res_t   res_o
);
  import wwalu_pkg::*;

  localparam int unsigned Depth = NumHalfs + 1;

  logic               adv;
  logic [Depth-1:0]   vld_q;
  chain_t             head_d, head_q;
  chain_t             stg [Depth];
  logic [WordW-1:0]   a_w, b_w, shl;
  logic               out_vld_q;
  res_t               out_q;

  assign adv         = !(res_valid_o && res_stall_i);
  assign req_stall_o = !adv;

  assign a_w = {req_i.a_limb3, req_i.a_limb2, req_i.a_limb1, req_i.a_limb0};
  assign b_w = {req_i.b_limb3, req_i.b_limb2, req_i.b_limb1, req_i.b_limb0};
  assign shl = (req_i.shift_bytes >= 8'd32) ? '0 :
               (a_w << {req_i.shift_bytes[4:0], 3'b000});

  always_comb begin
    head_d.kind = req_i.kind;
    head_d.a    = a_w;
    head_d.b    = b_w;
    head_d.acc  = (req_i.kind == OP_SHL) ? shl : '0;
    head_d.col  = '0;
    head_d.cy   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      head_q <= head_d;
    end
  end

  assign stg[0] = head_q;

  for (genvar j = 0; j < NumHalfs; j++) begin : g_cell
    wwalu_cell #(.Idx(j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .data_i (stg[j]),
      .data_o (stg[j+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], req_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= stg[Depth-1].acc;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;
endmodule

>>> rtl/core/wwalu_checker.sv
// Port-level checker for the 256-bit word arithmetic unit, bound to the top.
// Depends on wwalu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wwalu_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_stall_o,
  input logic            res_valid_o,
  input logic            res_stall_i,
  input wwalu_pkg::res_t res_o
);
  `ASSERT_CLK(a_res_hold, res_valid_o && res_stall_i |=> res_valid_o && $stable(res_o), "held")
  `ASSERT_CLK(a_stall_map, req_stall_o == (res_valid_o && res_stall_i), "stall not tied")
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !res_valid_o, "result after reset")
endmodule

bind wide_word_alu_256_unit wwalu_checker u_wwalu_checker (.*);

>>> tb/wide_word_alu_256_unit_chk.sv
// Checker for the 256-bit word arithmetic unit: watches both channels,
// predicts each result and compares it. Depends on wwalu_pkg.
`timescale 1ns / 100ps
module wide_word_alu_256_unit_chk (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_stall_i,
  input  wwalu_pkg::req_t req_i,
  input  logic            res_valid_i,
  input  logic            res_stall_i,
  input  wwalu_pkg::res_t res_i,
  output int              fail_count_o,
  output int              pending_o
);
  import wwalu_pkg::*;

  res_t expected_q[$];
  int   fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic res_t alu_predict(req_t rq);
    logic [255:0] a, b, r;
    res_t         o;
    a = {rq.a_limb3, rq.a_limb2, rq.a_limb1, rq.a_limb0};
    b = {rq.b_limb3, rq.b_limb2, rq.b_limb1, rq.b_limb0};
    case (rq.kind)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      default: begin
        if (rq.shift_bytes >= 8'd32) r = '0;
        else r = a << (rq.shift_bytes * 8);
      end
    endcase
    o = {r[255:192], r[191:128], r[127:64], r[63:0]};
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fails++;
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (req_valid_i && !req_stall_i) expected_q.push_back(alu_predict(req_i));
      if (res_valid_i && !res_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result at %0t", $time);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (res_i.r_limb3 !== want.r_limb3) report_mismatch("r_limb3", res_i.r_limb3, want.r_limb3);
          if (res_i.r_limb2 !== want.r_limb2) report_mismatch("r_limb2", res_i.r_limb2, want.r_limb2);
          if (res_i.r_limb1 !== want.r_limb1) report_mismatch("r_limb1", res_i.r_limb1, want.r_limb1);
          if (res_i.r_limb0 !== want.r_limb0) report_mismatch("r_limb0", res_i.r_limb0, want.r_limb0);
        end
      end
    end
  end
endmodule

>>> tb/wide_word_alu_256_unit_tb.sv
// Testbench top for the 256-bit word arithmetic unit: drives requests and
// result stalls, gives the verdict. Depends on wwalu_pkg and the checker.
`timescale 1ns / 100ps
module wide_word_alu_256_unit_tb;
  import wwalu_pkg::*;

  localparam int Latency = NumHalfs + 1;
  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  req_t req_i = '0;
  logic res_valid_o;
  logic res_stall_i = 1'b0;
  res_t res_o;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   n_sent = 0;
  int   n_kind[4] = '{0, 0, 0, 0};
  bit   sending = 1'b1;

  always #5 clk_i = ~clk_i;

  wide_word_alu_256_unit DUT (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .res_valid_o, .res_stall_i, .res_o
  );

  wide_word_alu_256_unit_chk u_chk (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_i(req_stall_o), .req_i,
    .res_valid_i(res_valid_o), .res_stall_i, .res_i(res_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stalls at random while stimulus runs, then drains freely.
  initial begin
    int g;
    @(posedge rst_ni);
    while (sending) begin
      @(negedge clk_i);
      g = gap_len();
      if (g > 0 && $urandom_range(0, 2) == 0) begin
        res_stall_i <= 1'b1;
        repeat (g) @(negedge clk_i);
        res_stall_i <= 1'b0;
      end
    end
    res_stall_i <= 1'b0;
  end

  function automatic logic [63:0] rand_limb();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.kind = op_e'($urandom_range(0, 3));
    r.a_limb3 = rand_limb(); r.a_limb2 = rand_limb();
    r.a_limb1 = rand_limb(); r.a_limb0 = rand_limb();
    r.b_limb3 = rand_limb(); r.b_limb2 = rand_limb();
    r.b_limb1 = rand_limb(); r.b_limb0 = rand_limb();
    r.shift_bytes = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 33));
    return r;
  endfunction

  function automatic req_t make_req(op_e k, logic [255:0] a, logic [255:0] b, logic [7:0] sh);
    req_t r;
    r.kind = k;
    {r.a_limb3, r.a_limb2, r.a_limb1, r.a_limb0} = a;
    {r.b_limb3, r.b_limb2, r.b_limb1, r.b_limb0} = b;
    r.shift_bytes = sh;
    return r;
  endfunction

  // Present one request and hold it until accepted.
  task automatic send_req(req_t r);
    req_i <= r;
    req_valid_i <= 1'b1;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    n_sent++;
    n_kind[r.kind]++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  initial begin
    logic [255:0] ones;
    req_t dir[$];
    ones = '1;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    dir.push_back(make_req(OP_ADD, ones, 256'd1, 8'hff));          // carry out dropped
    dir.push_back(make_req(OP_ADD, '0, '0, 8'd0));
    dir.push_back(make_req(OP_ADD, {4{64'hffff_ffff_ffff_ffff}}, ones, 8'd0));
    dir.push_back(make_req(OP_ADD, {192'd0, 64'hffff_ffff_ffff_ffff}, 256'd1, 8'd0));
    dir.push_back(make_req(OP_SUB, '0, 256'd1, 8'd0));               // borrow out dropped
    dir.push_back(make_req(OP_SUB, ones, ones, 8'hff));
    dir.push_back(make_req(OP_SUB, {64'd1, 192'd0}, 256'd1, 8'd0));
    dir.push_back(make_req(OP_MUL, ones, ones, 8'd0));               // high half dropped
    dir.push_back(make_req(OP_MUL, {128'd0, {128{1'b1}}}, {128'd0, {128{1'b1}}}, 8'd0));
    dir.push_back(make_req(OP_MUL, {1'b1, 255'd0}, 256'd2, 8'd0));
    dir.push_back(make_req(OP_MUL, ones, '0, 8'hff));
    dir.push_back(make_req(OP_SHL, ones, ones, 8'd0));
    dir.push_back(make_req(OP_SHL, ones, '0, 8'd1));
    dir.push_back(make_req(OP_SHL, ones, '0, 8'd8));
    dir.push_back(make_req(OP_SHL, ones, '0, 8'd13));
    dir.push_back(make_req(OP_SHL, ones, '0, 8'd31));
    dir.push_back(make_req(OP_SHL, ones, ones, 8'd32));              // large count gives zero
    dir.push_back(make_req(OP_SHL, ones, '0, 8'd255));
    dir.push_back(make_req(OP_SHL, '0, ones, 8'd4));
    foreach (dir[i]) send_req(dir[i]);

    for (int i = 0; i < 450; i++) begin
      if (i == 200) begin
        // hold off until every outstanding request has been answered
        req_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 3) != 0) idle_gap();
      send_req(rand_req());
    end
    req_valid_i <= 1'b0;
    sending = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    $display("sent %0d requests: add %0d, sub %0d, mul %0d, shift %0d",
             n_sent, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
    $display("random stalls on both channels, one full drain mid-run");
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/wwalu_pkg.sv
rtl/core/wwalu_cell.sv
rtl/core/wide_word_alu_256_unit.sv
rtl/core/wwalu_checker.sv
tb/wide_word_alu_256_unit_chk.sv
tb/wide_word_alu_256_unit_tb.sv
